// ===== sv/sofpa_pkg.sv =====
// package for the skip-one free page allocator
// holds sizes, codes and item types; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sofpa_pkg;

  // sizes of the page pool and of the allocation history
  localparam int NUM_PAGES   = 65536;
  localparam int HIST_DEPTH  = 512;
  localparam int PAGE_SHIFT  = 12;
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int LINK_W      = PAGE_W + 1;
  localparam int HIST_IDX_W  = $clog2(HIST_DEPTH);
  localparam int HIST_FILL_W = $clog2(HIST_DEPTH + 1);
  localparam int SEQ_W       = 32;
  localparam int CFG_W       = 17;

  // link value that marks the end of the list
  localparam logic [LINK_W-1:0] NULL_PAGE = LINK_W'(NUM_PAGES);

  typedef enum logic [1:0] {
    OP_FREE  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_HIST  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_FREE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_SHORT    = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_FIRST_PAGE = 1'b0,
    CFG_PAGE_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_LINK1,
    FSM_LINK2,
    FSM_HIST
  } fsm_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] page_address;
    logic [9:0]  frame_count;
    logic [8:0]  history_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] alloc_address;
    logic [31:0] history_value;
  } out_item_t;

  // request from the sequencer to the page store
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [PAGE_W-1:0] addr;
    logic [LINK_W-1:0] wr_link;
    logic [SEQ_W-1:0]  wr_seq;
  } store_req_t;

  // registered read data of the page store
  typedef struct packed {
    logic [LINK_W-1:0] rd_link;
    logic [SEQ_W-1:0]  rd_seq;
  } store_rsp_t;

endpackage
`default_nettype wire

// ===== sv/sofpa_page_store.sv =====
// per-page store: next link and free sequence tag of each page
// one access port, registered read data; uses sofpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module sofpa_page_store (
  input  wire logic                  clk_i,
  input  wire sofpa_pkg::store_req_t req_i,
  output      sofpa_pkg::store_rsp_t rsp_o
);

  logic [sofpa_pkg::LINK_W-1:0] link_mem [sofpa_pkg::NUM_PAGES];
  logic [sofpa_pkg::SEQ_W-1:0]  seq_mem  [sofpa_pkg::NUM_PAGES];
  logic [sofpa_pkg::LINK_W-1:0] rd_link_q;
  logic [sofpa_pkg::SEQ_W-1:0]  rd_seq_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      link_mem[req_i.addr] <= req_i.wr_link;
      seq_mem[req_i.addr]  <= req_i.wr_seq;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_link_q <= link_mem[req_i.addr];
      rd_seq_q  <= seq_mem[req_i.addr];
    end
  end

  assign rsp_o.rd_link = rd_link_q;
  assign rsp_o.rd_seq  = rd_seq_q;

endmodule
`default_nettype wire

// ===== sv/skip_one_free_page_allocator.sv =====
// free: result loaded in DECODE; allocate: result in DECODE on an empty list, in LINK1 when
// the list holds one page, in LINK2 otherwise (two dependent reads of the link memory)
// history read: result in DECODE when short, else in HIST (one history memory read)
// one item at a time; the next item is taken once the result register is free
// reset empties the list head and clears free counter and history fill; config registers reset to 0 and 57344;
// link, tag and history memories are undefined until written and need no clearing
`timescale 1ns / 1ps
`default_nettype none
module skip_one_free_page_allocator (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire sofpa_pkg::in_item_t  in_item_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      sofpa_pkg::out_item_t out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [0:0]           cfg_index_i,
  input  wire logic [sofpa_pkg::CFG_W-1:0] cfg_wdata_i
);

  sofpa_pkg::fsm_e                   state_q, state_d;
  sofpa_pkg::in_item_t               req_q, req_d;
  sofpa_pkg::out_item_t              out_q, out_d;
  logic                              out_valid_q, out_valid_d;
  logic [sofpa_pkg::LINK_W-1:0]      head_q, head_d;
  logic [sofpa_pkg::SEQ_W-1:0]       counter_q, counter_d;
  logic [sofpa_pkg::HIST_FILL_W-1:0] fill_q, fill_d;
  logic [15:0]                       first_page_q;
  logic [16:0]                       page_limit_q;

  sofpa_pkg::store_req_t             store_req;
  sofpa_pkg::store_rsp_t             store_rsp;

  logic [sofpa_pkg::SEQ_W-1:0]       hist_mem [sofpa_pkg::HIST_DEPTH];
  logic [sofpa_pkg::SEQ_W-1:0]       hist_rd_q;
  logic                              hist_we, hist_re;
  logic [sofpa_pkg::HIST_IDX_W-1:0]  hist_waddr, hist_raddr;

  logic                              in_accept, res_load;
  logic [19:0]                       free_pg;
  logic                              bad_free, hist_short;

  // page store instance
  sofpa_page_store u_store (
    .clk_i (clk_i),
    .req_i (store_req),
    .rsp_o (store_rsp)
  );

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = !((state_q == sofpa_pkg::FSM_IDLE) && (!out_valid_q || !out_stall_i));

  // address window check for a free
  assign free_pg  = req_q.page_address[31:sofpa_pkg::PAGE_SHIFT];
  assign bad_free = (req_q.page_address[sofpa_pkg::PAGE_SHIFT-1:0] != '0)
                 || (32'(free_pg) < 32'(first_page_q))
                 || (32'(free_pg) >= 32'(page_limit_q))
                 || (32'(free_pg) >= 32'(sofpa_pkg::NUM_PAGES));

  // history read range check
  assign hist_short = (32'(fill_q) < 32'(req_q.frame_count))
                   || (32'(req_q.history_index) >= 32'(fill_q))
                   || (32'(req_q.history_index) >= 32'(sofpa_pkg::HIST_DEPTH));

  // sequencer: next state, store accesses and result
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    out_d       = out_q;
    head_d      = head_q;
    counter_d   = counter_q;
    fill_d      = fill_q;
    res_load    = 1'b0;
    store_req   = '0;
    hist_we     = 1'b0;
    hist_re     = 1'b0;
    hist_waddr  = fill_q[sofpa_pkg::HIST_IDX_W-1:0];
    hist_raddr  = sofpa_pkg::HIST_IDX_W'(req_q.history_index);

    unique case (state_q)
      sofpa_pkg::FSM_IDLE: begin
        if (in_accept) begin
          req_d   = in_item_i;
          state_d = sofpa_pkg::FSM_DECODE;
        end
      end
      sofpa_pkg::FSM_DECODE: begin
        out_d = '0;
        unique case (sofpa_pkg::op_e'(req_q.op))
          sofpa_pkg::OP_FREE: begin
            res_load = 1'b1;
            state_d  = sofpa_pkg::FSM_IDLE;
            if (bad_free) begin
              out_d.status = sofpa_pkg::ST_BAD_FREE;
            end else begin
              store_req.wr_en   = 1'b1;
              store_req.addr    = sofpa_pkg::PAGE_W'(free_pg);
              store_req.wr_link = head_q;
              store_req.wr_seq  = counter_q;
              head_d            = sofpa_pkg::LINK_W'(free_pg);
              counter_d         = counter_q + 1'b1;
            end
          end
          sofpa_pkg::OP_ALLOC: begin
            if (head_q >= sofpa_pkg::NULL_PAGE) begin
              out_d.status = sofpa_pkg::ST_EMPTY;
              res_load     = 1'b1;
              state_d      = sofpa_pkg::FSM_IDLE;
            end else begin
              store_req.rd_en = 1'b1;
              store_req.addr  = head_q[sofpa_pkg::PAGE_W-1:0];
              state_d         = sofpa_pkg::FSM_LINK1;
            end
          end
          sofpa_pkg::OP_HIST: begin
            if (hist_short) begin
              out_d.status = sofpa_pkg::ST_SHORT;
              res_load     = 1'b1;
              state_d      = sofpa_pkg::FSM_IDLE;
            end else begin
              hist_re = 1'b1;
              state_d = sofpa_pkg::FSM_HIST;
            end
          end
          default: begin
            res_load = 1'b1;
            state_d  = sofpa_pkg::FSM_IDLE;
          end
        endcase
      end
      sofpa_pkg::FSM_LINK1: begin
        // log the popped page's tag, then follow to the page after it
        if (32'(fill_q) < 32'(sofpa_pkg::HIST_DEPTH)) begin
          hist_we = 1'b1;
          fill_d  = fill_q + 1'b1;
        end
        if (store_rsp.rd_link >= sofpa_pkg::NULL_PAGE) begin
          out_d.status        = sofpa_pkg::ST_OK;
          out_d.alloc_address = 32'(head_q[sofpa_pkg::PAGE_W-1:0]) << sofpa_pkg::PAGE_SHIFT;
          out_d.history_value = '0;
          head_d              = sofpa_pkg::NULL_PAGE;
          res_load            = 1'b1;
          state_d             = sofpa_pkg::FSM_IDLE;
        end else begin
          store_req.rd_en = 1'b1;
          store_req.addr  = store_rsp.rd_link[sofpa_pkg::PAGE_W-1:0];
          state_d         = sofpa_pkg::FSM_LINK2;
        end
      end
      sofpa_pkg::FSM_LINK2: begin
        // skipped page is dropped, its successor becomes the head
        out_d.status        = sofpa_pkg::ST_OK;
        out_d.alloc_address = 32'(head_q[sofpa_pkg::PAGE_W-1:0]) << sofpa_pkg::PAGE_SHIFT;
        out_d.history_value = '0;
        head_d              = store_rsp.rd_link;
        res_load            = 1'b1;
        state_d             = sofpa_pkg::FSM_IDLE;
      end
      sofpa_pkg::FSM_HIST: begin
        out_d.status        = sofpa_pkg::ST_OK;
        out_d.alloc_address = '0;
        out_d.history_value = hist_rd_q;
        res_load            = 1'b1;
        state_d             = sofpa_pkg::FSM_IDLE;
      end
      default: begin
        state_d = sofpa_pkg::FSM_IDLE;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sofpa_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= sofpa_pkg::NULL_PAGE;
      counter_q   <= '0;
      fill_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      counter_q   <= counter_d;
      fill_q      <= fill_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q <= 16'd0;
      page_limit_q <= 17'd57344;
    end else if (cfg_we_i) begin
      unique case (sofpa_pkg::cfg_reg_e'(cfg_index_i))
        sofpa_pkg::CFG_FIRST_PAGE: first_page_q <= cfg_wdata_i[15:0];
        sofpa_pkg::CFG_PAGE_LIMIT: page_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // allocation history log
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= store_rsp.rd_seq;
    end
    if (hist_re) begin
      hist_rd_q <= hist_mem[hist_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != sofpa_pkg::FSM_IDLE))
    else $error("accepted item did not start the sequencer");

  a_result_into_free_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !out_valid_q)
    else $error("result overwrote a pending item");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(sofpa_pkg::HIST_DEPTH))
    else $error("history fill beyond depth");

  a_empty_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != sofpa_pkg::ST_OK)) |->
      ((out_q.alloc_address == '0) && (out_q.history_value == '0)))
    else $error("error result carries data");

  a_head_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= sofpa_pkg::NULL_PAGE)
    else $error("list head out of range");

endmodule
`default_nettype wire
